// ----- rtl/masked_window_entropy_defines.svh -----
// ----------------------------------------------------------------------------
// masked_window_entropy_defines.svh
// Assertion macros shared by the masked window entropy block.
// ----------------------------------------------------------------------------
`ifndef MASKED_WINDOW_ENTROPY_DEFINES_SVH
`define MASKED_WINDOW_ENTROPY_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define MWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mwe_pkg.sv -----
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package mwe_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned ENT_W = 16;
  localparam logic [ENT_W-1:0] ENT_MAX = 16'hFFFF;

  // Parameter defaults
  localparam int unsigned MWE_GREY_LEVELS       = 256;
  localparam int unsigned MWE_MAX_WINDOW_PIXELS = 1024;
  localparam int unsigned MWE_FRACTION_BITS     = 12;

  // log2 mantissa: [1,2) with MANT_FRAC fraction bits
  localparam int unsigned MANT_FRAC = 30;
  localparam int unsigned MANT_W    = MANT_FRAC + 1;
  localparam int unsigned SHAMT_W   = $clog2(MANT_W);

  // Controller -> datapath
  typedef struct packed {
    logic pix_take;   // pixel transaction accepted, read its bin
    logic cnt_wr;     // write incremented bin count
    logic walk_clr;   // restart bin walk at bin 0
    logic walk_inc;   // advance bin walk
    logic acc_clr;    // clear c*log2(c) sum
    logic log_start;  // launch log2 unit
    logic log_sel_n;  // log2 operand is window total
    logic mul_load;   // register operand * log2
    logic acc_add;    // add product into sum
    logic diff_load;  // load clamped n*L(n) - S
    logic div_init;   // add rounding term, reset divider
    logic div_step;   // one quotient bit
    logic res_load;   // load result, clear histogram
  } mwe_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic counted;     // pixel is masked and window has room
    logic in_last;     // pixel closes the window
    logic bin_nonzero; // walked bin holds a count
    logic walk_last;   // walk sits on the top bin
    logic total_zero;  // no masked pixel in the window
    logic log_busy;
    logic log_done;
    logic div_done;
    logic out_free;    // result register can take a new value
  } mwe_sts_t;

endpackage

// ----- rtl/mwe_if.sv -----
// ----------------------------------------------------------------------------
// mwe_if
// Valid/ready channels: pixel input and entropy result.
// ----------------------------------------------------------------------------
interface mwe_in_if import mwe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             in_mask;
  logic             window_end;

  modport source (output valid, output pixel_value, output in_mask, output window_end,
                  input ready);
  modport sink   (input valid, input pixel_value, input in_mask, input window_end,
                  output ready);
endinterface

interface mwe_out_if import mwe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ENT_W-1:0] entropy_bits;
  logic             window_empty;

  modport source (output valid, output entropy_bits, output window_empty, input ready);
  modport sink   (input valid, input entropy_bits, input window_empty, output ready);
endinterface

// ----- rtl/mwe_ram.sv -----
// ----------------------------------------------------------------------------
// mwe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mwe_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mwe_log2.sv -----
// ----------------------------------------------------------------------------
// mwe_log2
// Fixed-point log2 of a count: integer part by leading-one search, fraction
// bits MSB first by repeated squaring of the mantissa, one bit per cycle.
// ----------------------------------------------------------------------------
module mwe_log2 import mwe_pkg::*; #(
  parameter int unsigned CNT_W         = $clog2(MWE_MAX_WINDOW_PIXELS + 1),
  parameter int unsigned FRACTION_BITS = MWE_FRACTION_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [CNT_W-1:0]                         x,
  output logic                                     busy,
  output logic                                     done,
  output logic [$clog2(CNT_W)+FRACTION_BITS-1:0]   log_out
);

  localparam int unsigned E_W    = $clog2(CNT_W);
  localparam int unsigned STEP_W = $clog2(FRACTION_BITS + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [STEP_W-1:0]        step_r;
  logic [E_W-1:0]           e_r;
  logic [MANT_W-1:0]        m_r;
  logic [FRACTION_BITS-1:0] frac_r;

  logic [E_W-1:0]      e_nxt;
  logic [MANT_W-1:0]   m_init;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     msq;
  logic                fbit;
  logic [MANT_W-1:0]   m_step;

  // leading one
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) begin
        e_nxt = E_W'(i);
      end
    end
  end

  assign m_init = MANT_W'(x) << (SHAMT_W'(MANT_FRAC) - SHAMT_W'(e_nxt));

  // square, rescale, renormalize
  assign sq     = {{MANT_W{1'b0}}, m_r} * {{MANT_W{1'b0}}, m_r};
  assign msq    = sq[2*MANT_W-1:MANT_FRAC];
  assign fbit   = msq[MANT_W];
  assign m_step = fbit ? msq[MANT_W:1] : msq[MANT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRACTION_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e_r    <= e_nxt;
      m_r    <= m_init;
      frac_r <= '0;
    end else if (busy_r) begin
      m_r    <= m_step;
      frac_r <= {frac_r[FRACTION_BITS-2:0], fbit};
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign log_out = {e_r, frac_r};

endmodule

// ----- rtl/mwe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwe_ctrl
// Sequencer: pixel counting, bin walk, log/accumulate, divide, result hand-off.
// ----------------------------------------------------------------------------
module mwe_ctrl import mwe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mwe_sts_t sts,
  output mwe_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_START,
    S_SCAN,
    S_LOG_C,
    S_ACC_C,
    S_LOG_N,
    S_DIFF,
    S_DINIT,
    S_DIV,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.pix_take = 1'b1;
          last_nxt     = sts.in_last;
          if (sts.counted) begin
            state_nxt = S_INC;
          end else if (sts.in_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_INC: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = last_r ? S_START : S_IDLE;
      end
      S_START: begin
        if (sts.total_zero) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.walk_clr = 1'b1;
          cmd.acc_clr  = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.bin_nonzero) begin
          cmd.log_start = 1'b1;
          state_nxt     = S_LOG_C;
        end else if (sts.walk_last) begin
          cmd.log_start = 1'b1;
          cmd.log_sel_n = 1'b1;
          state_nxt     = S_LOG_N;
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      S_LOG_C: begin
        if (sts.log_done) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_ACC_C;
        end
      end
      S_ACC_C: begin
        cmd.acc_add = 1'b1;
        if (sts.walk_last) begin
          cmd.log_start = 1'b1;
          cmd.log_sel_n = 1'b1;
          state_nxt     = S_LOG_N;
        end else begin
          cmd.walk_inc = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_LOG_N: begin
        if (sts.log_done) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff_load = 1'b1;
        state_nxt     = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- rtl/mwe_datapath.sv -----
// ----------------------------------------------------------------------------
// mwe_datapath
// Histogram RAM with valid bits, log2 unit, multiply-accumulate, restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module mwe_datapath import mwe_pkg::*; #(
  parameter int unsigned GREY_LEVELS       = MWE_GREY_LEVELS,
  parameter int unsigned MAX_WINDOW_PIXELS = MWE_MAX_WINDOW_PIXELS,
  parameter int unsigned FRACTION_BITS     = MWE_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [PIX_W-1:0] in_pixel_value,
  input  logic             in_mask,
  input  logic             in_window_end,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [ENT_W-1:0] out_entropy_bits,
  output logic             out_window_empty,
  input  mwe_cmd_t         cmd,
  output mwe_sts_t         sts
);

  localparam int unsigned BIN_W   = $clog2(GREY_LEVELS);
  localparam int unsigned TOP_BIN = GREY_LEVELS - 1;
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int unsigned E_W     = $clog2(CNT_W);
  localparam int unsigned LOG_W   = E_W + FRACTION_BITS;
  localparam int unsigned PROD_W  = CNT_W + LOG_W;
  localparam int unsigned NUM_W   = PROD_W + 1;
  localparam int unsigned DCNT_W  = $clog2(NUM_W + 1);
  localparam int unsigned SAT_W   = (NUM_W > ENT_W) ? NUM_W : ENT_W + 1;

  // histogram
  logic [PIX_W:0]           pix_ext;
  logic [BIN_W-1:0]         pix_bin;
  logic [BIN_W-1:0]         bin_r;
  logic [BIN_W-1:0]         walk_idx_r, walk_idx_nxt;
  logic [BIN_W-1:0]         rd_addr;
  logic [CNT_W-1:0]         ram_q;
  logic [GREY_LEVELS-1:0]   vld_r;
  logic                     vld_q_r;
  logic [CNT_W-1:0]         bin_cnt;
  logic [CNT_W-1:0]         total_r;

  // entropy arithmetic
  logic [CNT_W-1:0]         log_x;
  logic [CNT_W-1:0]         x_r;
  logic [LOG_W-1:0]         log_res;
  logic                     log_busy;
  logic                     log_done;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W-1:0]        s_r;

  // divider
  logic [NUM_W-1:0]         div_num_r;
  logic [CNT_W-1:0]         div_rem_r;
  logic [DCNT_W-1:0]        div_cnt_r;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           rem_diff;
  logic                     rem_ge;

  // result
  logic [SAT_W-1:0]         num_wide;
  logic [ENT_W-1:0]         ent_sat;
  logic                     out_valid_r;
  logic [ENT_W-1:0]         out_ent_r;
  logic                     out_empty_r;

  // grey levels above the top bin land in the top bin
  assign pix_ext = {1'b0, in_pixel_value};
  assign pix_bin = (pix_ext > (PIX_W + 1)'(TOP_BIN)) ? BIN_W'(TOP_BIN) : pix_ext[BIN_W-1:0];

  always_comb begin
    walk_idx_nxt = walk_idx_r;
    if (cmd.walk_clr) begin
      walk_idx_nxt = '0;
    end else if (cmd.walk_inc) begin
      walk_idx_nxt = walk_idx_r + BIN_W'(1);
    end
  end

  assign rd_addr = cmd.pix_take ? pix_bin : walk_idx_nxt;
  assign bin_cnt = vld_q_r ? ram_q : '0;

  mwe_ram #(
    .WIDTH (CNT_W),
    .DEPTH (GREY_LEVELS)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.cnt_wr),
    .waddr (bin_r),
    .wdata (bin_cnt + CNT_W'(1)),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    vld_q_r    <= vld_r[rd_addr];
    if (cmd.pix_take) begin
      bin_r <= pix_bin;
    end
  end

  // valid bits stand in for clearing the RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      total_r <= '0;
    end else if (cmd.res_load) begin
      vld_r   <= '0;
      total_r <= '0;
    end else if (cmd.cnt_wr) begin
      vld_r[bin_r] <= 1'b1;
      total_r      <= total_r + CNT_W'(1);
    end
  end

  assign log_x = cmd.log_sel_n ? total_r : bin_cnt;

  mwe_log2 #(
    .CNT_W         (CNT_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.log_start),
    .x       (log_x),
    .busy    (log_busy),
    .done    (log_done),
    .log_out (log_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.log_start) begin
      x_r <= log_x;
    end
    if (cmd.mul_load) begin
      prod_r <= {{LOG_W{1'b0}}, x_r} * {{CNT_W{1'b0}}, log_res};
    end
    if (cmd.acc_clr) begin
      s_r <= '0;
    end else if (cmd.acc_add) begin
      s_r <= s_r + prod_r;
    end
  end

  // restoring divide, quotient bits shift into the dividend register
  assign rem_sh   = {div_rem_r, div_num_r[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, total_r};
  assign rem_diff = rem_sh - {1'b0, total_r};

  always_ff @(posedge clk) begin
    if (cmd.diff_load) begin
      div_num_r <= (prod_r > s_r) ? NUM_W'(prod_r - s_r) : '0;
    end else if (cmd.div_init) begin
      div_num_r <= div_num_r + NUM_W'(total_r >> 1);
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_num_r <= {div_num_r[NUM_W-2:0], rem_ge};
      div_rem_r <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_init) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  assign num_wide = SAT_W'(div_num_r);
  assign ent_sat  = (num_wide > SAT_W'(ENT_MAX)) ? ENT_MAX : num_wide[ENT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ent_r   <= (total_r == '0) ? '0 : ent_sat;
      out_empty_r <= (total_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entropy_bits = out_ent_r;
  assign out_window_empty = out_empty_r;

  assign sts.counted     = in_mask && (total_r < CNT_W'(MAX_WINDOW_PIXELS));
  assign sts.in_last     = in_window_end;
  assign sts.bin_nonzero = (bin_cnt != '0);
  assign sts.walk_last   = (walk_idx_r == BIN_W'(TOP_BIN));
  assign sts.total_zero  = (total_r == '0);
  assign sts.log_busy    = log_busy;
  assign sts.log_done    = log_done;
  assign sts.div_done    = (div_cnt_r == DCNT_W'(NUM_W));
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

// ----- rtl/masked_window_entropy.sv -----
// ----------------------------------------------------------------------------
// masked_window_entropy
// Shannon entropy, in bits, of the masked grey levels of one window.
// ----------------------------------------------------------------------------
// Pixels stream in one transaction at a time. Masked pixels are counted into
// a GREY_LEVELS-bin histogram (levels above the top bin go to the top bin;
// masked pixels past MAX_WINDOW_PIXELS are dropped). The transaction flagged
// window_end closes the window and yields one result transaction:
// H = log2(n) - (1/n)*sum c*log2(c), unsigned with FRACTION_BITS fraction
// bits, rounded to nearest, saturated at 0xFFFF; an empty window gives 0 with
// window_empty set. The histogram is then empty again for the next window.
//
// A masked pixel takes a histogram RAM read, then write-back of the
// incremented count, and the next pixel is not accepted before the
// write-back; an unmasked pixel is accepted alone. Closing a non-empty
// window walks over the bins, one bin a cycle while the bins are empty (an
// occupied bin holds the walk while the shared log2 unit, one fraction bit
// per cycle, 31x31 squaring, works on its count), then takes log2 of the
// window total and runs the restoring divider (one quotient bit per cycle).
// No pixel is taken while a window is being closed.
// The result sits in an output register; the next window's pixels are
// accepted while it waits, and only the next close's result load waits for it to drain.
// The histogram needs no clearing pass: a valid bit per bin, all cleared
// together at reset and with each result load, masks stale RAM contents.
// ----------------------------------------------------------------------------
`include "masked_window_entropy_defines.svh"

module masked_window_entropy import mwe_pkg::*; #(
  parameter int unsigned GREY_LEVELS       = MWE_GREY_LEVELS,
  parameter int unsigned MAX_WINDOW_PIXELS = MWE_MAX_WINDOW_PIXELS,
  parameter int unsigned FRACTION_BITS     = MWE_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  mwe_in_if.sink           in_ch,
  mwe_out_if.source        out_ch
);

  mwe_cmd_t cmd;
  mwe_sts_t sts;
  logic     in_ready;

  // Sequencer: owns the input handshake and steps the datapath.
  mwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Histogram, log2, accumulate, divide and the result register.
  mwe_datapath #(
    .GREY_LEVELS       (GREY_LEVELS),
    .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_pixel_value   (in_ch.pixel_value),
    .in_mask          (in_ch.in_mask),
    .in_window_end    (in_ch.window_end),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_entropy_bits (out_ch.entropy_bits),
    .out_window_empty (out_ch.window_empty),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign in_ch.ready = in_ready;

  // A new result never lands on one that has not been taken.
  `MWE_ASSERT(a_no_result_overwrite, cmd.res_load |-> sts.out_free, "result overwritten")
  // An accepted pixel that counts is written back on the next cycle.
  `MWE_ASSERT(a_count_writeback, (in_ch.valid && in_ch.ready && sts.counted) |=> cmd.cnt_wr, "count lost")
  // The shared log2 unit is launched only when idle.
  `MWE_ASSERT(a_log_start_idle, cmd.log_start |-> !sts.log_busy, "log2 unit restarted while busy")
  // Reset leaves no result pending.
  `MWE_ASSERT_ALWAYS(a_reset_out_idle, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule
